### sv/djdr_pkg.sv
// ----------------------------------------------------------------------------
// djdr_pkg: shared types and constants of the dual joystick report core
// Sizes, report and item layouts, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package djdr_pkg;

   localparam int NUM_BUTTONS       = 13;
   localparam int NUM_PLAYERS       = 2;
   localparam int TICK_WIDTH        = 32;

   localparam int INPUTS_PER_PLAYER = 4 + NUM_BUTTONS;
   localparam int PIN_BITS          = 17;
   localparam int REPORT_SLOTS      = 2;
   localparam int BTN_FIELD_BITS    = 13;
   localparam int SENT_BTN_BITS     = 16;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [7:0]  AXIS_REST      = 8'd127;
   localparam logic [7:0]  AXIS_MAX       = 8'd255;
   localparam logic [7:0]  AXIS_MIN       = 8'd0;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [15:0] SENT_BTN_RESET = 16'hFFFF;

   localparam logic        KIND_STATUS = 1'b0;
   localparam logic        KIND_REPORT = 1'b1;
   localparam logic [1:0]  RID_NONE    = 2'd0;
   localparam logic [1:0]  RID_FIRST   = 2'd1;
   localparam logic [1:0]  RID_SECOND  = 2'd2;

   typedef enum logic [1:0] {
      REG_DEBOUNCE_MS = 2'd0,
      REG_PLAYER_SWAP = 2'd1,
      REG_PRESS_LOW   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STATUS,
      ST_REPORT1,
      ST_REPORT2
   } seq_state_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic        player_swap;
      logic        press_low;
   } cfg_type;

   typedef struct packed {
      logic [7:0]               axis_x;
      logic [7:0]               axis_y;
      logic [SENT_BTN_BITS-1:0] buttons;
   } report_type;

   typedef struct packed {
      report_type rpt;
      logic       led;
   } lane_sum_type;

   typedef struct packed {
      logic                      kind;
      logic [1:0]                report_num;
      logic [7:0]                axis_x;
      logic [7:0]                axis_y;
      logic [BTN_FIELD_BITS-1:0] button_mask;
      logic                      led_p1;
      logic                      led_p2;
      logic                      last;
   } rsp_item_type;

endpackage

### sv/djdr_lane.sv
// ----------------------------------------------------------------------------
// djdr_lane: debounce and report build for one player
// Every input has its own change timer; the debounced states give the axes,
// the button mask and the activity flag of this player.
// ----------------------------------------------------------------------------
module djdr_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [djdr_pkg::PIN_BITS-1:0]        pins,
   input  logic [djdr_pkg::TICK_WIDTH-1:0]      now,
   input  djdr_pkg::cfg_type                    cfg,
   output djdr_pkg::lane_sum_type               sum
);

   localparam int N_IN    = djdr_pkg::INPUTS_PER_PLAYER;
   localparam int LEVEL_W = (N_IN > djdr_pkg::PIN_BITS) ? N_IN : djdr_pkg::PIN_BITS;
   localparam int TW      = djdr_pkg::TICK_WIDTH;

   logic [LEVEL_W-1:0] level_w;
   logic [N_IN-1:0]    db_ff;
   logic [N_IN-1:0]    db_in;
   logic [TW-1:0]      ct_ff [N_IN];
   logic [TW-1:0]      ct_in [N_IN];
   logic [TW-1:0]      hold_time;
   logic [djdr_pkg::SENT_BTN_BITS-1:0] btn_w;

   // Inputs beyond the pin field read level zero.
   assign level_w   = LEVEL_W'(pins);
   assign hold_time = TW'(cfg.debounce_ms);

   genvar i;
   generate
      for (i = 0; i < N_IN; i++) begin : g_input
         logic          pressed;
         logic [TW-1:0] elapsed;
         logic          take;
         assign pressed  = level_w[i] ^ cfg.press_low;
         assign elapsed  = now - ct_ff[i];
         assign take     = step && (pressed != db_ff[i]) && (elapsed >= hold_time);
         assign db_in[i] = take ? pressed : db_ff[i];
         assign ct_in[i] = take ? now : ct_ff[i];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff <= '0;
         for (int k = 0; k < N_IN; k++) begin
            ct_ff[k] <= '0;
         end
      end else begin
         db_ff <= db_in;
         for (int k = 0; k < N_IN; k++) begin
            ct_ff[k] <= ct_in[k];
         end
      end
   end

   genvar b;
   generate
      for (b = 0; b < djdr_pkg::SENT_BTN_BITS; b++) begin : g_btn
         if (b < djdr_pkg::NUM_BUTTONS && b < djdr_pkg::BTN_FIELD_BITS) begin : g_used
            assign btn_w[b] = db_ff[4 + b];
         end else begin : g_unused
            assign btn_w[b] = 1'b0;
         end
      end
   endgenerate

   // Down overrides up and right overrides left.
   always_comb begin
      sum.rpt.axis_x = djdr_pkg::AXIS_REST;
      sum.rpt.axis_y = djdr_pkg::AXIS_REST;
      if (db_ff[0]) sum.rpt.axis_y = djdr_pkg::AXIS_MIN;
      if (db_ff[1]) sum.rpt.axis_y = djdr_pkg::AXIS_MAX;
      if (db_ff[2]) sum.rpt.axis_x = djdr_pkg::AXIS_MIN;
      if (db_ff[3]) sum.rpt.axis_x = djdr_pkg::AXIS_MAX;
      sum.rpt.buttons = btn_w;
      sum.led         = |db_ff;
   end

endmodule

### sv/djdr_merge.sv
// ----------------------------------------------------------------------------
// djdr_merge: merges the lane results into the output item sequence
// Emits the status item, then, with usb_ready set, every changed report,
// through an output register that holds while the result side stalls.
// ----------------------------------------------------------------------------
module djdr_merge (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_valid,
   output logic                                               req_ready,
   input  logic                                               req_usb_ready,
   input  djdr_pkg::lane_sum_type [djdr_pkg::REPORT_SLOTS-1:0] lane_sum,
   input  logic                                               player_swap,
   output logic                                               rsp_valid,
   input  logic                                               rsp_ready,
   output djdr_pkg::rsp_item_type                             rsp_item
);

   djdr_pkg::seq_state_type state_ff, state_in;

   logic                   usb_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   djdr_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                   load_item;
   logic                   out_free;

   djdr_pkg::report_type [djdr_pkg::REPORT_SLOTS-1:0] sent_ff;
   djdr_pkg::report_type [djdr_pkg::REPORT_SLOTS-1:0] rep_ff;
   djdr_pkg::report_type [djdr_pkg::REPORT_SLOTS-1:0] rep_sel;
   logic [djdr_pkg::REPORT_SLOTS-1:0] send_ff;
   logic [djdr_pkg::REPORT_SLOTS-1:0] send_in;
   logic [djdr_pkg::REPORT_SLOTS-1:0] led_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == djdr_pkg::ST_IDLE);

   // Report r carries the other player when the swap is set.
   always_comb begin
      for (int r = 0; r < djdr_pkg::REPORT_SLOTS; r++) begin
         rep_sel[r] = lane_sum[1'(r) ^ player_swap].rpt;
         send_in[r] = usb_ff && (rep_sel[r] != sent_ff[r]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         djdr_pkg::ST_IDLE: begin
            if (req_valid) state_in = djdr_pkg::ST_LOAD;
         end
         djdr_pkg::ST_LOAD: begin
            state_in = djdr_pkg::ST_STATUS;
         end
         djdr_pkg::ST_STATUS: begin
            if (out_free) begin
               if (send_ff[0])      state_in = djdr_pkg::ST_REPORT1;
               else if (send_ff[1]) state_in = djdr_pkg::ST_REPORT2;
               else                 state_in = djdr_pkg::ST_IDLE;
            end
         end
         djdr_pkg::ST_REPORT1: begin
            if (out_free) begin
               state_in = send_ff[1] ? djdr_pkg::ST_REPORT2 : djdr_pkg::ST_IDLE;
            end
         end
         djdr_pkg::ST_REPORT2: begin
            if (out_free) state_in = djdr_pkg::ST_IDLE;
         end
         default: state_in = djdr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      load_item             = 1'b0;
      rsp_in                = '0;
      rsp_in.kind           = djdr_pkg::KIND_REPORT;
      unique case (state_ff)
         djdr_pkg::ST_STATUS: begin
            load_item     = out_free;
            rsp_in.kind   = djdr_pkg::KIND_STATUS;
            rsp_in.report_num = djdr_pkg::RID_NONE;
            rsp_in.led_p1 = led_ff[0];
            rsp_in.led_p2 = led_ff[1];
            rsp_in.last   = !send_ff[0] && !send_ff[1];
         end
         djdr_pkg::ST_REPORT1: begin
            load_item          = out_free;
            rsp_in.report_num  = djdr_pkg::RID_FIRST;
            rsp_in.axis_x      = rep_ff[0].axis_x;
            rsp_in.axis_y      = rep_ff[0].axis_y;
            rsp_in.button_mask = rep_ff[0].buttons[djdr_pkg::BTN_FIELD_BITS-1:0];
            rsp_in.last        = !send_ff[1];
         end
         djdr_pkg::ST_REPORT2: begin
            load_item          = out_free;
            rsp_in.report_num  = djdr_pkg::RID_SECOND;
            rsp_in.axis_x      = rep_ff[1].axis_x;
            rsp_in.axis_y      = rep_ff[1].axis_y;
            rsp_in.button_mask = rep_ff[1].buttons[djdr_pkg::BTN_FIELD_BITS-1:0];
            rsp_in.last        = 1'b1;
         end
         default: load_item = 1'b0;
      endcase
      rsp_valid_in = load_item ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= djdr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         send_ff      <= '0;
         for (int r = 0; r < djdr_pkg::REPORT_SLOTS; r++) begin
            sent_ff[r] <= '{axis_x: djdr_pkg::AXIS_MAX, axis_y: djdr_pkg::AXIS_MAX,
                            buttons: djdr_pkg::SENT_BTN_RESET};
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == djdr_pkg::ST_LOAD) begin
            send_ff <= send_in;
            for (int r = 0; r < djdr_pkg::REPORT_SLOTS; r++) begin
               if (send_in[r]) sent_ff[r] <= rep_sel[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) usb_ff <= req_usb_ready;
      if (state_ff == djdr_pkg::ST_LOAD) begin
         rep_ff <= rep_sel;
         for (int r = 0; r < djdr_pkg::REPORT_SLOTS; r++) begin
            led_ff[r] <= lane_sum[r].led;
         end
      end
      if (load_item) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_load_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == djdr_pkg::ST_LOAD) |-> $past(req_valid && req_ready))
      else $error("sequencer left idle without an accepted transaction");

   a_report2_only_when_sent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == djdr_pkg::ST_REPORT1 || state_ff == djdr_pkg::ST_REPORT2)
      |-> (state_ff == djdr_pkg::ST_REPORT1 ? send_ff[0] : send_ff[1]))
      else $error("report state entered for an unchanged report");

   a_report_no_leds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == djdr_pkg::KIND_REPORT)
      |-> (!rsp_ff.led_p1 && !rsp_ff.led_p2 && rsp_ff.report_num != djdr_pkg::RID_NONE))
      else $error("report item carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == djdr_pkg::KIND_STATUS)
      |-> (rsp_ff.report_num == djdr_pkg::RID_NONE && rsp_ff.button_mask == '0))
      else $error("status item carries report fields");

endmodule

### sv/dual_joystick_debounce_report_core.sv
// ----------------------------------------------------------------------------
// dual_joystick_debounce_report_core: debounced two-player joystick reporter
// One lane per player debounces its inputs; the merge stage emits a status
// item and, with usb_ready set, every report changed since it was last sent.
//
//   channel  | handshake             | payload
//   req      | req_valid / req_ready | pins_p1, pins_p2, now_ms, usb_ready
//   rsp      | rsp_valid / rsp_ready | kind .. last, one item per transaction
//   csr      | psel/penable/pready   | paddr, pwdata, prdata (regs at 4*i)
//
// A scan produces one to three items: the debounce timers update at
// acceptance, the load state latches the lane reports, then one item leaves
// per cycle while the result side does not stall.
// The next scan is taken once the sequencer has loaded its last item.
// Reset clears debounce states and timers, presets sent reports and registers.
// A stalled result side holds the sequencer in its current item.
// ----------------------------------------------------------------------------
module dual_joystick_debounce_report_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [djdr_pkg::PIN_BITS-1:0]          req_pins_p1,
   input  logic [djdr_pkg::PIN_BITS-1:0]          req_pins_p2,
   input  logic [31:0]                            req_now_ms,
   input  logic                                   req_usb_ready,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_kind,
   output logic [1:0]                             rsp_report_num,
   output logic [7:0]                             rsp_axis_x,
   output logic [7:0]                             rsp_axis_y,
   output logic [djdr_pkg::BTN_FIELD_BITS-1:0]    rsp_button_mask,
   output logic                                   rsp_led_p1,
   output logic                                   rsp_led_p2,
   output logic                                   rsp_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [djdr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [djdr_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [djdr_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready
);

   djdr_pkg::cfg_type      cfg_ff;
   djdr_pkg::reg_index_type reg_sel;
   djdr_pkg::rsp_item_type rsp_item;
   djdr_pkg::lane_sum_type [djdr_pkg::REPORT_SLOTS-1:0] lane_sum;
   logic [djdr_pkg::PIN_BITS-1:0] pins_w [djdr_pkg::REPORT_SLOTS];
   logic                          step;
   logic                          csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = djdr_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= djdr_pkg::DEBOUNCE_RESET;
         cfg_ff.player_swap <= 1'b0;
         cfg_ff.press_low   <= 1'b1;
      end else if (csr_write) begin
         unique case (reg_sel)
            djdr_pkg::REG_DEBOUNCE_MS: cfg_ff.debounce_ms <= pwdata[15:0];
            djdr_pkg::REG_PLAYER_SWAP: cfg_ff.player_swap <= pwdata[0];
            djdr_pkg::REG_PRESS_LOW:   cfg_ff.press_low   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         djdr_pkg::REG_DEBOUNCE_MS: prdata = 32'(cfg_ff.debounce_ms);
         djdr_pkg::REG_PLAYER_SWAP: prdata = 32'(cfg_ff.player_swap);
         djdr_pkg::REG_PRESS_LOW:   prdata = 32'(cfg_ff.press_low);
         default:                   prdata = '0;
      endcase
   end

   assign pins_w[0] = req_pins_p1;
   assign pins_w[1] = req_pins_p2;

   genvar p;
   generate
      for (p = 0; p < djdr_pkg::REPORT_SLOTS; p++) begin : g_lane
         if (p < djdr_pkg::NUM_PLAYERS) begin : g_player
            djdr_lane u_lane (
               .clock (clock),
               .reset (reset),
               .step  (step),
               .pins  (pins_w[p]),
               .now   (req_now_ms[djdr_pkg::TICK_WIDTH-1:0]),
               .cfg   (cfg_ff),
               .sum   (lane_sum[p])
            );
         end else begin : g_absent
            // An absent player reports centered axes, no buttons, no activity.
            assign lane_sum[p] = '{rpt: '{axis_x: djdr_pkg::AXIS_REST,
                                          axis_y: djdr_pkg::AXIS_REST,
                                          buttons: '0},
                                   led: 1'b0};
         end
      end
   endgenerate

   djdr_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_usb_ready (req_usb_ready),
      .lane_sum      (lane_sum),
      .player_swap   (cfg_ff.player_swap),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item)
   );

   assign rsp_kind        = rsp_item.kind;
   assign rsp_report_num  = rsp_item.report_num;
   assign rsp_axis_x      = rsp_item.axis_x;
   assign rsp_axis_y      = rsp_item.axis_y;
   assign rsp_button_mask = rsp_item.button_mask;
   assign rsp_led_p1      = rsp_item.led_p1;
   assign rsp_led_p2      = rsp_item.led_p2;
   assign rsp_last        = rsp_item.last;

endmodule

### tb/joystick_report_checker.sv
// ----------------------------------------------------------------------------
// joystick_report_checker: scan predictor and result comparator
// Follows the register writes and every accepted scan, debounces a private
// copy of all player inputs, and checks each result transaction against the
// oldest predicted status or report item.
// ----------------------------------------------------------------------------
module joystick_report_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [djdr_pkg::PIN_BITS-1:0]          req_pins_p1,
   input  logic [djdr_pkg::PIN_BITS-1:0]          req_pins_p2,
   input  logic [31:0]                            req_now_ms,
   input  logic                                   req_usb_ready,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   rsp_kind,
   input  logic [1:0]                             rsp_report_num,
   input  logic [7:0]                             rsp_axis_x,
   input  logic [7:0]                             rsp_axis_y,
   input  logic [djdr_pkg::BTN_FIELD_BITS-1:0]    rsp_button_mask,
   input  logic                                   rsp_led_p1,
   input  logic                                   rsp_led_p2,
   input  logic                                   rsp_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [djdr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [djdr_pkg::CSR_DATA_BITS-1:0]     pwdata,
   input  logic                                   pready,
   output int                                     fail_count,
   output int                                     items_owed
);

   localparam int NUM_INPUTS = djdr_pkg::NUM_PLAYERS * djdr_pkg::INPUTS_PER_PLAYER;
   localparam int MAX_REPORTED = 10;

   djdr_pkg::cfg_type              cfg;
   logic                           held_pressed [NUM_INPUTS];
   logic [djdr_pkg::TICK_WIDTH-1:0] change_stamp [NUM_INPUTS];
   djdr_pkg::report_type           sent_report [djdr_pkg::REPORT_SLOTS];
   djdr_pkg::rsp_item_type         items_due [$];
   int                             fails = 0;

   function automatic string item_text(input djdr_pkg::rsp_item_type it);
      return $sformatf("kind=%0d id=%0d x=%0d y=%0d buttons=%h led=%b%b last=%b",
                       it.kind, it.report_num, it.axis_x, it.axis_y, it.button_mask,
                       it.led_p1, it.led_p2, it.last);
   endfunction

   // Debounces every input of one scan, then queues the status item and, when usb
   // is set, each report that differs from the one last sent under that id.
   function automatic void debounce_and_build(input logic [djdr_pkg::PIN_BITS-1:0] p1,
                                              input logic [djdr_pkg::PIN_BITS-1:0] p2,
                                              input logic [31:0] now,
                                              input logic usb);
      logic [djdr_pkg::PIN_BITS-1:0]   pins [djdr_pkg::NUM_PLAYERS];
      djdr_pkg::report_type            lane [djdr_pkg::REPORT_SLOTS];
      logic                            led [djdr_pkg::REPORT_SLOTS];
      djdr_pkg::rsp_item_type          item [3];
      djdr_pkg::report_type            pick;
      logic                            level;
      logic                            pressed;
      logic [djdr_pkg::TICK_WIDTH-1:0] elapsed;
      int                              k;
      int                              n;
      pins[0] = p1;
      pins[1] = p2;
      for (int s = 0; s < djdr_pkg::REPORT_SLOTS; s++) begin
         lane[s] = '{axis_x: djdr_pkg::AXIS_REST, axis_y: djdr_pkg::AXIS_REST,
                     buttons: '0};
         led[s] = 1'b0;
      end
      for (int p = 0; p < djdr_pkg::NUM_PLAYERS; p++) begin
         for (int i = 0; i < djdr_pkg::INPUTS_PER_PLAYER; i++) begin
            k = p * djdr_pkg::INPUTS_PER_PLAYER + i;
            level = (i < djdr_pkg::PIN_BITS) ? pins[p][i] : 1'b0;
            pressed = cfg.press_low ? !level : level;
            if (pressed != held_pressed[k]) begin
               elapsed = now[djdr_pkg::TICK_WIDTH-1:0] - change_stamp[k];
               if (elapsed >= djdr_pkg::TICK_WIDTH'(cfg.debounce_ms)) begin
                  held_pressed[k] = pressed;
                  change_stamp[k] = now[djdr_pkg::TICK_WIDTH-1:0];
               end
            end
            if (held_pressed[k]) begin
               led[p] = 1'b1;
               // Later directions win: down over up, right over left.
               case (i)
                  0: lane[p].axis_y = djdr_pkg::AXIS_MIN;
                  1: lane[p].axis_y = djdr_pkg::AXIS_MAX;
                  2: lane[p].axis_x = djdr_pkg::AXIS_MIN;
                  3: lane[p].axis_x = djdr_pkg::AXIS_MAX;
                  default: begin
                     if (i - 4 < djdr_pkg::BTN_FIELD_BITS) lane[p].buttons[i - 4] = 1'b1;
                  end
               endcase
            end
         end
      end
      item[0] = '{kind: djdr_pkg::KIND_STATUS, report_num: djdr_pkg::RID_NONE,
                  axis_x: '0, axis_y: '0, button_mask: '0,
                  led_p1: led[0], led_p2: led[1], last: 1'b0};
      n = 1;
      if (usb) begin
         for (int r = 0; r < djdr_pkg::REPORT_SLOTS; r++) begin
            pick = lane[r ^ int'(cfg.player_swap)];
            if (pick != sent_report[r]) begin
               sent_report[r] = pick;
               item[n] = '{kind: djdr_pkg::KIND_REPORT,
                           report_num: (r == 0) ? djdr_pkg::RID_FIRST : djdr_pkg::RID_SECOND,
                           axis_x: pick.axis_x, axis_y: pick.axis_y,
                           button_mask: pick.buttons[djdr_pkg::BTN_FIELD_BITS-1:0],
                           led_p1: 1'b0, led_p2: 1'b0, last: 1'b0};
               n++;
            end
         end
      end
      item[n - 1].last = 1'b1;
      for (int j = 0; j < n; j++) items_due.push_back(item[j]);
   endfunction

   always @(posedge clock) begin : watch
      djdr_pkg::rsp_item_type got;
      djdr_pkg::rsp_item_type want;
      if (reset) begin
         cfg = '{debounce_ms: djdr_pkg::DEBOUNCE_RESET, player_swap: 1'b0,
                 press_low: 1'b1};
         for (int k = 0; k < NUM_INPUTS; k++) begin
            held_pressed[k] = 1'b0;
            change_stamp[k] = '0;
         end
         for (int s = 0; s < djdr_pkg::REPORT_SLOTS; s++) begin
            sent_report[s] = '{axis_x: djdr_pkg::AXIS_MAX, axis_y: djdr_pkg::AXIS_MAX,
                               buttons: djdr_pkg::SENT_BTN_RESET};
         end
         items_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (djdr_pkg::reg_index_type'(paddr[djdr_pkg::CSR_ADDR_BITS-1:2]))
               djdr_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms = pwdata[15:0];
               djdr_pkg::REG_PLAYER_SWAP: cfg.player_swap = pwdata[0];
               djdr_pkg::REG_PRESS_LOW:   cfg.press_low   = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            debounce_and_build(req_pins_p1, req_pins_p2, req_now_ms, req_usb_ready);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{kind: rsp_kind, report_num: rsp_report_num, axis_x: rsp_axis_x,
                    axis_y: rsp_axis_y, button_mask: rsp_button_mask, led_p1: rsp_led_p1,
                    led_p2: rsp_led_p2, last: rsp_last};
            if (items_due.size() == 0) begin
               fails++;
               if (fails <= MAX_REPORTED) begin
                  $display("unexpected result transaction: %s", item_text(got));
               end
            end else begin
               want = items_due.pop_front();
               if (got.kind !== want.kind || got.report_num !== want.report_num ||
                   got.axis_x !== want.axis_x || got.axis_y !== want.axis_y ||
                   got.button_mask !== want.button_mask || got.led_p1 !== want.led_p1 ||
                   got.led_p2 !== want.led_p2 || got.last !== want.last) begin
                  fails++;
                  if (fails <= MAX_REPORTED) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("   expected %s", item_text(want));
                     $display("   actual   %s", item_text(got));
                  end
               end
            end
         end
      end
      fail_count <= fails;
      items_owed <= items_due.size();
   end

endmodule

### tb/dual_joystick_debounce_report_core_test.sv
// ----------------------------------------------------------------------------
// dual_joystick_debounce_report_core_test: stimulus and verdict
// Drives directed and random scans through several debounce, swap and
// polarity settings, with random gaps and result stalls; a checker beside
// the core predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module dual_joystick_debounce_report_core_test;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RUN_LIMIT      = 2_000_000;
   localparam int PHASE_SCANS    = 66;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PIN_W          = djdr_pkg::PIN_BITS;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [PIN_W-1:0]                     req_pins_p1 = '1;
   logic [PIN_W-1:0]                     req_pins_p2 = '1;
   logic [31:0]                          req_now_ms = '0;
   logic                                 req_usb_ready = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic                                 rsp_kind;
   logic [1:0]                           rsp_report_num;
   logic [7:0]                           rsp_axis_x;
   logic [7:0]                           rsp_axis_y;
   logic [djdr_pkg::BTN_FIELD_BITS-1:0]  rsp_button_mask;
   logic                                 rsp_led_p1;
   logic                                 rsp_led_p2;
   logic                                 rsp_last;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [djdr_pkg::CSR_ADDR_BITS-1:0]   paddr = '0;
   logic [djdr_pkg::CSR_DATA_BITS-1:0]   pwdata = '0;
   logic [djdr_pkg::CSR_DATA_BITS-1:0]   prdata;
   logic                                 pready;

   int                                   idle_pct = 17;
   int                                   stall_pct = 17;
   int                                   fail_count;
   int                                   items_owed;
   logic [31:0]                          tick = '0;
   logic [PIN_W-1:0]                     hold_p1 = '1;
   logic [PIN_W-1:0]                     hold_p2 = '1;

   dual_joystick_debounce_report_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pins_p1     (req_pins_p1),
      .req_pins_p2     (req_pins_p2),
      .req_now_ms      (req_now_ms),
      .req_usb_ready   (req_usb_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_report_num  (rsp_report_num),
      .rsp_axis_x      (rsp_axis_x),
      .rsp_axis_y      (rsp_axis_y),
      .rsp_button_mask (rsp_button_mask),
      .rsp_led_p1      (rsp_led_p1),
      .rsp_led_p2      (rsp_led_p2),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   joystick_report_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pins_p1     (req_pins_p1),
      .req_pins_p2     (req_pins_p2),
      .req_now_ms      (req_now_ms),
      .req_usb_ready   (req_usb_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_report_num  (rsp_report_num),
      .rsp_axis_x      (rsp_axis_x),
      .rsp_axis_y      (rsp_axis_y),
      .rsp_button_mask (rsp_button_mask),
      .rsp_led_p1      (rsp_led_p1),
      .rsp_led_p2      (rsp_led_p2),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .items_owed      (items_owed)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_scan(input logic [PIN_W-1:0] p1, input logic [PIN_W-1:0] p2,
                            input logic [31:0] now, input logic usb);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pins_p1   <= p1;
      req_pins_p2   <= p2;
      req_now_ms    <= now;
      req_usb_ready <= usb;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds off new scans until every predicted item has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (items_owed != 0);
   endtask

   task automatic csr_write(input djdr_pkg::reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] debounce, input logic swap, input logic low);
      drain();
      csr_write(djdr_pkg::REG_DEBOUNCE_MS, {16'h0, debounce});
      csr_write(djdr_pkg::REG_PLAYER_SWAP, {31'h0, swap});
      csr_write(djdr_pkg::REG_PRESS_LOW, {31'h0, low});
   endtask

   function automatic logic [PIN_W-1:0] pick_pattern();
      case ($urandom_range(5))
         0: return '1;
         1: return '0;
         2: return ~(PIN_W'(1) << $urandom_range(PIN_W - 1));
         3: return PIN_W'(1) << $urandom_range(PIN_W - 1);
         default: return PIN_W'($urandom());
      endcase
   endfunction

   // Players hold a pattern over several scans; single-scan bounces and
   // jumps of the tick are mixed in as noise.
   task automatic random_scans(input int count, input int span);
      logic [PIN_W-1:0] p1;
      logic [PIN_W-1:0] p2;
      int unsigned      roll;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 15) hold_p1 = pick_pattern();
         if ($urandom_range(99) < 15) hold_p2 = pick_pattern();
         p1 = hold_p1;
         p2 = hold_p2;
         if ($urandom_range(99) < 20) p1 ^= PIN_W'(1) << $urandom_range(PIN_W - 1);
         if ($urandom_range(99) < 20) p2 ^= PIN_W'(1) << $urandom_range(PIN_W - 1);
         roll = $urandom_range(99);
         if (roll < 60) tick += $urandom_range(8);
         else if (roll < 90) tick += $urandom_range(span);
         else tick = $urandom();
         send_scan(p1, p2, tick, $urandom_range(99) < 85);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 20 ticks of debounce, low level means pressed.
      send_scan(17'h1FFFF, 17'h1FFFF, 32'd0, 1'b1);
      send_scan(17'h1FFFF, 17'h1FFFF, 32'd0, 1'b1);
      send_scan(17'h00000, 17'h00000, 32'd5, 1'b1);
      send_scan(17'h00000, 17'h00000, 32'd20, 1'b1);
      send_scan(17'h1FFFF, 17'h00000, 32'd21, 1'b0);
      send_scan(17'h1FFFF, 17'h00000, 32'd45, 1'b0);
      send_scan(17'h1FFFF, 17'h00000, 32'd46, 1'b1);
      send_scan(17'h1FFFE, 17'h1FFFF, 32'd70, 1'b1);
      send_scan(17'h1FFFB, 17'h1FFFC, 32'd100, 1'b1);
      send_scan(17'h1FFF3, 17'h0AAAF, 32'd130, 1'b1);
      send_scan(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1);
      // The tick wraps here: six ticks are too soon, twenty are enough.
      send_scan(17'h00000, 17'h00000, 32'h0000_0005, 1'b1);
      send_scan(17'h00000, 17'h00000, 32'h0000_0013, 1'b1);
      send_scan(17'h00000, 17'h00000, 32'h0000_0013, 1'b1);
      tick = 32'd200;
      random_scans(PHASE_SCANS, 28);

      configure(16'd0, 1'b1, 1'b1);
      random_scans(PHASE_SCANS / 2, 8);
      drain();
      random_scans(PHASE_SCANS - PHASE_SCANS / 2, 8);

      configure(16'hFFFF, 1'b0, 1'b0);
      random_scans(PHASE_SCANS, 70000);

      idle_pct  = 0;
      stall_pct = 0;
      configure(16'd5, 1'b1, 1'b0);
      random_scans(PHASE_SCANS, 13);

      idle_pct  = 17;
      stall_pct = 17;
      configure(16'($urandom_range(50)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      tick = 32'hFFFF_FF00;
      random_scans(PHASE_SCANS, 58);

      configure(16'd1, 1'b0, 1'b1);
      random_scans(PHASE_SCANS, 9);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && items_owed == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
